[rtl/core/assert_macros.svh]
// Assertion macros shared by the stepper sequencer RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while reset is high.
`define SEQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked property, also evaluated during reset.
`define SEQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/stpseq_pkg.sv]
// Package for the four-wire full-step stepper sequencer.
// Holds the item kind codes, register indexes, reset values, the sequencer
// state type and the coil pattern table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stpseq_pkg;

  typedef enum logic [0:0] {
    KIND_TICK = 1'b0,
    KIND_MOVE = 1'b1
  } kind_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_PERIOD   = 2'd0,
    REG_STEPS_PER_REV = 2'd1
  } cfg_reg_t;

  localparam logic [31:0] STEP_PERIOD_RESET   = 32'd1000;
  localparam logic [15:0] STEPS_PER_REV_RESET = 16'd200;

  // Architectural state other than the elapsed timer, whose width is a parameter.
  typedef struct packed {
    logic [3:0]  coils;
    logic [15:0] position;
    logic [15:0] remaining;
    logic        forward;
    logic [31:0] steps_taken;
  } seq_state_t;

  localparam seq_state_t SEQ_STATE_RESET = '{
    coils:       4'b0000,
    position:    16'd0,
    remaining:   16'd0,
    forward:     1'b0,
    steps_taken: 32'd0
  };

  // Full-step drive pattern for position mod 4; wire one is the MSB.
  function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
    logic [3:0] pat;
    case (phase)
      2'd0:    pat = 4'b1010;
      2'd1:    pat = 4'b0110;
      2'd2:    pat = 4'b0101;
      2'd3:    pat = 4'b1001;
      default: pat = 4'b0000;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

[rtl/core/stpseq_in_if.sv]
// Input channel of the stepper sequencer: valid/ready plus one command item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface stpseq_in_if;
  logic              valid;
  logic              ready;
  logic [0:0]        kind;
  logic signed [15:0] move_steps;

  modport source (output valid, output kind, output move_steps, input ready);
  modport sink   (input valid, input kind, input move_steps, output ready);
endinterface

`default_nettype wire

[rtl/core/stpseq_out_if.sv]
// Result channel of the stepper sequencer: valid/ready plus one status item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface stpseq_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  coils;
  logic [15:0] position;
  logic [15:0] steps_remaining;
  logic        stepped;
  logic        moving_forward;
  logic [31:0] steps_taken;

  modport source (output valid, output coils, output position, output steps_remaining,
                  output stepped, output moving_forward, output steps_taken,
                  input ready);
  modport sink   (input valid, input coils, input position, input steps_remaining,
                  input stepped, input moving_forward, input steps_taken,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/stepper_full_step_sequencer.sv]
// Top level of the four-wire full-step stepper sequencer.
// Depends on stpseq_pkg, stpseq_in_if, stpseq_out_if, stpseq_step_unit and
// assert_macros.svh.
//
//   Channel  Direction  Carries
//   in_ch    sink       kind (tick or move command), move_steps
//   out_ch   source     coils, position, steps_remaining, stepped,
//                       moving_forward, steps_taken
//   cfg      write      step_period (index 0), steps_per_rev (index 1)
//
// Every transaction passes from input to result through the input register, then
// through the step logic into the result register.
// One transaction is accepted per cycle unless the result register stalls. The state
// is updated as an item leaves the input register, so the next item sees the new state.
// Reset (rst, synchronous) clears the state to position 0, reverse, no steps left.
// A stalled result register holds a full input register, which then drops ready.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stepper_full_step_sequencer
  import stpseq_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  stpseq_in_if.sink             in_ch,
  stpseq_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [31:0] step_period;
  logic [15:0] steps_per_rev;

  // Input register.
  logic               s1_valid;
  kind_t              s1_kind;
  logic signed [15:0] s1_move_steps;

  // Sequencer state.
  seq_state_t             state;
  logic [TIMER_WIDTH-1:0] elapsed;

  // Step logic results.
  seq_state_t             state_next;
  logic [TIMER_WIDTH-1:0] elapsed_next;
  logic                   step_fire;

  // Result register.
  logic        out_valid;
  logic        out_stepped;
  seq_state_t  out_state;

  logic advance;
  logic in_ready;

  assign advance  = ~out_valid | out_ch.ready;
  assign in_ready = ~s1_valid | advance;

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid;
  assign out_ch.coils           = out_state.coils;
  assign out_ch.position        = out_state.position;
  assign out_ch.steps_remaining = out_state.remaining;
  assign out_ch.stepped         = out_stepped;
  assign out_ch.moving_forward  = out_state.forward;
  assign out_ch.steps_taken     = out_state.steps_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period   <= STEP_PERIOD_RESET;
      steps_per_rev <= STEPS_PER_REV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_PERIOD:   step_period   <= cfg_data[31:0];
        REG_STEPS_PER_REV: steps_per_rev <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ready) begin
      s1_kind       <= kind_t'(in_ch.kind);
      s1_move_steps <= in_ch.move_steps;
    end
  end

  stpseq_step_unit #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .kind          (s1_kind),
    .move_steps    (s1_move_steps),
    .cur           (state),
    .elapsed       (elapsed),
    .step_period   (step_period),
    .steps_per_rev (steps_per_rev),
    .upd           (state_next),
    .elapsed_next  (elapsed_next),
    .stepped       (step_fire)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SEQ_STATE_RESET;
      elapsed   <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        state   <= state_next;
        elapsed <= elapsed_next;
      end
    end
    if (advance && s1_valid) begin
      out_state   <= state_next;
      out_stepped <= step_fire;
    end
  end

  // A step always restarts the step timer.
  `SEQ_ASSERT(a_step_clears_timer, clk, rst, (advance && s1_valid && step_fire) |=> (elapsed == '0), "step did not clear the elapsed timer")
  // A move command never produces a step.
  `SEQ_ASSERT(a_move_no_step, clk, rst, (advance && s1_valid && (s1_kind == KIND_MOVE)) |=> !out_stepped, "move command reported a step")
  // The remaining count never exceeds the magnitude of the most negative move.
  `SEQ_ASSERT(a_remaining_range, clk, rst, (state.remaining <= 16'h8000), "steps left out of range")
  // Coils are either all off or one of the two-wire full-step patterns.
  `SEQ_ASSERT(a_coil_shape, clk, rst, (state.coils != 4'b0000) |-> ($countones(state.coils) == 2), "illegal coil pattern")
  // A result waiting on the output holds the input register in place.
  `SEQ_ASSERT(a_stall_holds_s1, clk, rst, (s1_valid && !advance) |=> (s1_valid && $stable(s1_move_steps) && $stable(s1_kind)), "input register changed while stalled")

endmodule

`default_nettype wire

[rtl/core/stpseq_step_unit.sv]
// Combinational next-state logic of the stepper sequencer for one item.
// Depends on stpseq_pkg for the state type, kind codes and coil table.
`timescale 1ns / 1ps
`default_nettype none

module stpseq_step_unit
  import stpseq_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 32
) (
  input  kind_t                   kind,
  input  logic signed [15:0]      move_steps,
  input  seq_state_t              cur,
  input  logic [TIMER_WIDTH-1:0]  elapsed,
  input  logic [31:0]             step_period,
  input  logic [15:0]             steps_per_rev,
  output seq_state_t              upd,
  output logic [TIMER_WIDTH-1:0]  elapsed_next,
  output logic                    stepped
);

  localparam int unsigned CMP_W = (TIMER_WIDTH > 32) ? TIMER_WIDTH : 32;

  logic [TIMER_WIDTH-1:0] elapsed_inc;
  logic [16:0]            rev;
  logic [16:0]            pos_ext;
  logic [16:0]            pos_up;
  logic [16:0]            pos_new;
  logic [15:0]            magnitude;
  logic                   step_due;

  always_comb begin
    // Saturating tick counter.
    elapsed_inc = (&elapsed) ? elapsed : elapsed + TIMER_WIDTH'(1);
    step_due = (cur.remaining != 16'd0) &&
               (CMP_W'(elapsed_inc) >= CMP_W'(step_period));

    // A zero revolution length means the full 16-bit range.
    rev     = (steps_per_rev == 16'd0) ? 17'h10000 : {1'b0, steps_per_rev};
    pos_ext = {1'b0, cur.position};
    pos_up  = pos_ext + 17'd1;
    if (cur.forward) begin
      pos_new = (pos_up >= rev) ? 17'd0 : pos_up;
    end else if ((cur.position == 16'd0) || (pos_ext >= rev)) begin
      pos_new = rev - 17'd1;
    end else begin
      pos_new = pos_ext - 17'd1;
    end

    // Two's complement magnitude; the most negative count maps to 0x8000.
    magnitude = move_steps[15] ? (16'd0 - move_steps) : move_steps;

    upd          = cur;
    elapsed_next = elapsed;
    stepped      = 1'b0;
    if (kind == KIND_MOVE) begin
      upd.remaining = magnitude;
      if (move_steps != 16'sd0) begin
        upd.forward = ~move_steps[15];
      end
    end else begin
      elapsed_next = elapsed_inc;
      if (step_due) begin
        stepped          = 1'b1;
        upd.position     = pos_new[15:0];
        upd.remaining    = cur.remaining - 16'd1;
        upd.steps_taken  = cur.steps_taken + 32'd1;
        upd.coils        = coil_pattern(pos_new[1:0]);
        elapsed_next     = '0;
      end
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb_stepper_full_step_sequencer.sv]
// Self-checking testbench for the four-wire full-step stepper sequencer.
// Depends on stpseq_pkg, stpseq_in_if, stpseq_out_if and the sequencer RTL; it
// predicts every status transaction and compares it field by field.
`timescale 1ns / 1ps

module tb_stepper_full_step_sequencer;
  import stpseq_pkg::*;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] count;
  } command_t;

  typedef struct packed {
    logic [3:0]  coils;
    logic [15:0] position;
    logic [15:0] steps_remaining;
    logic        stepped;
    logic        moving_forward;
    logic [31:0] steps_taken;
  } status_t;

  // An index that decodes to no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [3:0] DRIVE_PATTERN [4] = '{4'b1010, 4'b0110, 4'b0101, 4'b1001};
  localparam int unsigned DRAIN_CYCLES = 4;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  stpseq_in_if  in_ch ();
  stpseq_out_if out_ch ();

  stepper_full_step_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  command_t command_q[$];
  status_t  predicted_status[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned results_seen;
  logic        in_taken;

  // Predicted sequencer state and register copies.
  logic [31:0] period_cfg;
  logic [15:0] rev_cfg;
  logic [15:0] seq_position;
  logic        seq_forward;
  logic [15:0] seq_left;
  logic [31:0] seq_elapsed;
  logic [3:0]  seq_coils;
  logic [31:0] seq_taken;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic status_t advance_sequencer(command_t c);
    status_t     r;
    logic [16:0] rev;
    logic [16:0] nxt;
    r.stepped = 1'b0;
    if (c.kind == KIND_MOVE) begin
      // The most negative count has no positive twin; its magnitude is 0x8000.
      seq_left = c.count[15] ? (~c.count + 16'd1) : c.count;
      if (c.count != 16'sd0) begin
        seq_forward = !c.count[15];
      end
    end else begin
      if (seq_elapsed != '1) begin
        seq_elapsed = seq_elapsed + 32'd1;
      end
      if (seq_left != 16'd0 && seq_elapsed >= period_cfg) begin
        rev = (rev_cfg == 16'd0) ? 17'h10000 : {1'b0, rev_cfg};
        if (seq_forward) begin
          nxt = {1'b0, seq_position} + 17'd1;
          seq_position = (nxt >= rev) ? 16'd0 : nxt[15:0];
        end else if (seq_position == 16'd0 || {1'b0, seq_position} >= rev) begin
          seq_position = 16'(rev - 17'd1);
        end else begin
          seq_position = seq_position - 16'd1;
        end
        seq_left    = seq_left - 16'd1;
        seq_taken   = seq_taken + 32'd1;
        seq_coils   = DRIVE_PATTERN[seq_position[1:0]];
        seq_elapsed = '0;
        r.stepped   = 1'b1;
      end
    end
    r.coils           = seq_coils;
    r.position        = seq_position;
    r.steps_remaining = seq_left;
    r.moving_forward  = seq_forward;
    r.steps_taken     = seq_taken;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: status %0d: %s", $time, results_seen, what);
    end
  endtask

  task automatic check_status(input status_t got);
    status_t want;
    if (predicted_status.size() == 0) begin
      report_mismatch("status transaction with nothing predicted");
    end else begin
      want = predicted_status.pop_front();
      if (got.coils !== want.coils)
        report_mismatch($sformatf("coils %b, predicted %b", got.coils, want.coils));
      if (got.position !== want.position)
        report_mismatch($sformatf("position %0d, predicted %0d", got.position,
                                  want.position));
      if (got.steps_remaining !== want.steps_remaining)
        report_mismatch($sformatf("steps_remaining %0d, predicted %0d",
                                  got.steps_remaining, want.steps_remaining));
      if (got.stepped !== want.stepped)
        report_mismatch($sformatf("stepped %b, predicted %b", got.stepped, want.stepped));
      if (got.moving_forward !== want.moving_forward)
        report_mismatch($sformatf("moving_forward %b, predicted %b", got.moving_forward,
                                  want.moving_forward));
      if (got.steps_taken !== want.steps_taken)
        report_mismatch($sformatf("steps_taken %0d, predicted %0d", got.steps_taken,
                                  want.steps_taken));
    end
    results_seen++;
  endtask

  // Monitor: results are checked before this edge's input is predicted, so the
  // queue order matches the block's order.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        check_status('{out_ch.coils, out_ch.position, out_ch.steps_remaining,
                       out_ch.stepped, out_ch.moving_forward, out_ch.steps_taken});
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted_status.push_back(advance_sequencer('{kind_t'(in_ch.kind),
                                                       in_ch.move_steps}));
      end
    end
  end

  // Command driver: a new transaction is offered only once the previous one was taken.
  always @(negedge clk) begin
    command_t c;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (command_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c = command_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= c.kind;
        in_ch.move_steps <= c.count;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_command(input kind_t k, input int n);
    command_q.push_back('{k, 16'(n)});
  endtask

  task automatic queue_random(input int unsigned count);
    command_t    c;
    int unsigned pick;
    repeat (count) begin
      c.kind  = ($urandom_range(99) < 25) ? KIND_MOVE : KIND_TICK;
      c.count = 16'($urandom);
      if (c.kind == KIND_MOVE) begin
        pick = $urandom_range(99);
        // Mostly short moves so that moves finish and the direction changes often.
        if (pick < 65) begin
          c.count = 16'($urandom_range(12, 1));
          if ($urandom_range(1) == 1) c.count = -c.count;
        end else if (pick < 72) begin
          c.count = 16'sd0;
        end
      end
      command_q.push_back(c);
    end
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (command_q.size() != 0 || in_ch.valid || predicted_status.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_STEP_PERIOD) period_cfg = value;
    else if (idx == REG_STEPS_PER_REV) rev_cfg = value[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #3_000_000;
    $display("tb_stepper_full_step_sequencer failed");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_STEP_PERIOD;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_TICK;
    in_ch.move_steps = '0;
    out_ch.ready     = 1'b0;
    send_idle_pct    = 19;
    recv_idle_pct    = 66;
    mismatches       = 0;
    results_seen     = 0;
    period_cfg       = STEP_PERIOD_RESET;
    rev_cfg          = STEPS_PER_REV_RESET;
    seq_position     = SEQ_STATE_RESET.position;
    seq_forward      = SEQ_STATE_RESET.forward;
    seq_left         = SEQ_STATE_RESET.remaining;
    seq_coils        = SEQ_STATE_RESET.coils;
    seq_taken        = SEQ_STATE_RESET.steps_taken;
    seq_elapsed      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: zero count keeps reverse, both count extremes, idle ticks.
    queue_command(KIND_MOVE, 0);
    queue_command(KIND_MOVE, -32768);
    queue_command(KIND_TICK, 0);
    queue_command(KIND_MOVE, 32767);
    queue_command(KIND_TICK, -1);
    wait_idle();

    // Zero revolution size wraps at the 16-bit boundary.
    write_register(REG_STEP_PERIOD, 32'd1);
    write_register(REG_STEPS_PER_REV, 16'd0);
    write_register(REG_UNUSED, 32'd5);
    queue_command(KIND_MOVE, -3);
    repeat (4) queue_command(KIND_TICK, 0);
    wait_idle();

    // Positions above the new revolution size, reverse then forward.
    write_register(REG_STEPS_PER_REV, 16'd9);
    write_register(REG_STEP_PERIOD, 32'd0);
    queue_command(KIND_MOVE, -1);
    queue_command(KIND_TICK, 0);
    queue_command(KIND_MOVE, 1);
    queue_command(KIND_TICK, 0);
    wait_idle();
    write_register(REG_STEPS_PER_REV, 16'd0);
    queue_command(KIND_MOVE, -2);
    repeat (2) queue_command(KIND_TICK, 0);
    wait_idle();
    write_register(REG_STEPS_PER_REV, 16'd9);
    write_register(REG_STEP_PERIOD, 32'd2);
    queue_command(KIND_MOVE, 2);
    repeat (3) queue_command(KIND_TICK, 0);
    wait_idle();

    write_register(REG_STEP_PERIOD, 32'd3);
    write_register(REG_STEPS_PER_REV, 16'd200);
    send_idle_pct = 19;
    recv_idle_pct = 66;
    queue_random(125);
    wait_idle();
    queue_random(125);
    wait_idle();

    write_register(REG_STEP_PERIOD, 32'd0);
    write_register(REG_STEPS_PER_REV, 16'd7);
    send_idle_pct = 66;
    recv_idle_pct = 19;
    queue_random(250);
    wait_idle();

    write_register(REG_STEP_PERIOD, 32'd1);
    write_register(REG_STEPS_PER_REV, 16'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(150);
    wait_idle();

    write_register(REG_STEP_PERIOD, 32'hFFFF_FFFF);
    write_register(REG_STEPS_PER_REV, 16'd65535);
    queue_random(50);
    wait_idle();

    write_register(REG_STEP_PERIOD, 32'd0);
    queue_random(50);
    wait_idle();

    if (mismatches == 0) begin
      $display("tb_stepper_full_step_sequencer passed");
    end else begin
      $display("tb_stepper_full_step_sequencer failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/stpseq_pkg.sv
rtl/core/stpseq_in_if.sv
rtl/core/stpseq_out_if.sv
rtl/core/stpseq_step_unit.sv
rtl/core/stepper_full_step_sequencer.sv
tb/sv/tb_stepper_full_step_sequencer.sv
